// ===== hdl/attribute_filter_match_engine_top_defines.svh =====
// assertion macros shared by the checker of the match engine
// expects clk and rst_n in the scope that uses them
`ifndef ATTRIBUTE_FILTER_MATCH_ENGINE_TOP_DEFINES_SVH
`define ATTRIBUTE_FILTER_MATCH_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define AFME_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("match engine assertion failed");

// next-cycle implication, off during reset
`define AFME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("match engine assertion failed");

`endif

// ===== hdl/afme_pkg.sv =====
// shared types, constants and codes of the attribute filter match engine
// no dependencies
package afme_pkg;

  localparam int MAX_USERS      = 64;
  localparam int SLOTS_PER_USER = 16;
  localparam int FIELD_W        = 31;
  localparam int UIDX_W         = $clog2(MAX_USERS);
  localparam int UCNT_W         = $clog2(MAX_USERS + 1);
  localparam int SCNT_W         = $clog2(SLOTS_PER_USER + 1);
  localparam int SIDX_W         = (SLOTS_PER_USER > 1) ? $clog2(SLOTS_PER_USER) : 1;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  // combine codes
  localparam logic [1:0] COMB_AND = 2'd1;
  localparam logic [1:0] COMB_OR  = 2'd2;

  // predicate test codes
  localparam logic TEST_EQUAL = 1'b0;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_USERS_FULL = 2'd1;
  localparam logic [1:0] ST_SLOTS_FULL = 2'd2;
  localparam logic [1:0] ST_UNKNOWN    = 2'd3;

  // action codes of the input item
  localparam logic [1:0] ACT_DECLARE = 2'd0;
  localparam logic [1:0] ACT_SET     = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  typedef enum logic [1:0] {OP_DECLARE, OP_SET, OP_QUERY, OP_NOP} op_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCAN, BK_SHIFT_RD, BK_SHIFT_WR, BK_INSERT
  } bk_state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [FIELD_W-1:0] user_id;
    logic [FIELD_W-1:0] attr_a;
    logic [FIELD_W-1:0] value_a;
    logic               test_a;
    logic [1:0]         combine;
    logic [FIELD_W-1:0] attr_b;
    logic [FIELD_W-1:0] value_b;
    logic               test_b;
  } in_item_t;

  typedef struct packed {
    logic               has_match;
    logic [FIELD_W-1:0] match_user;
    logic               last;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] attr;
    logic [FIELD_W-1:0] value;
  } slot_t;

  // one user record: key, slot fill and all slots side by side
  typedef struct packed {
    logic [FIELD_W-1:0]                key;
    logic [SCNT_W-1:0]                 count;
    slot_t [SLOTS_PER_USER-1:0]        slots;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic     vld;
    op_t      op;
    in_item_t item;
  } q_head_t;

endpackage

// ===== hdl/afme_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module afme_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/afme_front.sv =====
// front end: accepts items, classifies the action and queues commands
// depends on afme_pkg
module afme_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  afme_pkg::in_item_t in_item,
  input  logic               pop,
  output afme_pkg::q_head_t  head
);
  import afme_pkg::*;

  op_t               q_op_r   [QDEPTH];
  in_item_t          q_item_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  op_t               op_cls;

  // classify the action code
  always_comb begin
    case (in_item.action)
      ACT_DECLARE: op_cls = OP_DECLARE;
      ACT_SET:     op_cls = OP_SET;
      ACT_QUERY:   op_cls = OP_QUERY;
      default:     op_cls = OP_NOP;
    endcase
  end

  assign busy = (cnt_r == QCNT_W'(QDEPTH));
  assign push = start && !busy;

  // pointer and fill bookkeeping
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_op_r[wp_r]   <= op_cls;
      q_item_r[wp_r] <= in_item;
    end
  end

  assign head.vld  = (cnt_r != '0);
  assign head.op   = q_op_r[rp_r];
  assign head.item = q_item_r[rp_r];

endmodule

// ===== hdl/afme_back.sv =====
// back end: runs declare, set and query commands over the user table
// depends on afme_pkg and afme_ram
module afme_back (
  input  logic                clk,
  input  logic                rst_n,
  input  afme_pkg::q_head_t   head,
  output logic                pop,
  output logic                out_valid,
  output afme_pkg::out_item_t out_item
);
  import afme_pkg::*;

  bk_state_t          state_r, state_nxt;
  op_t                op_r, op_nxt;
  in_item_t           cmd_r, cmd_nxt;
  logic [UCNT_W-1:0]  n_r, n_nxt;
  logic [UCNT_W-1:0]  iss_r, iss_nxt;
  logic               rv_r, rv_nxt;
  logic [UIDX_W-1:0]  ridx_r, ridx_nxt;
  logic [UCNT_W-1:0]  pos_r, pos_nxt;
  logic [UCNT_W-1:0]  sh_r, sh_nxt;
  logic               pend_r, pend_nxt;
  logic [FIELD_W-1:0] pkey_r, pkey_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               we;
  logic [UIDX_W-1:0]  waddr, raddr;
  logic [ROW_W-1:0]   wdata, rdata;
  row_t               row, row_upd;
  logic               hit_any;
  logic [SIDX_W-1:0]  hit_idx;
  logic               pa, pb, qmatch;
  logic               go_insert;
  logic [UCNT_W-1:0]  sh_dec;

  function automatic out_item_t mk_out(logic hit, logic [FIELD_W-1:0] user,
                                       logic lst, logic [1:0] st);
    out_item_t o;
    o.has_match  = hit;
    o.match_user = user;
    o.last       = lst;
    o.status     = st;
    return o;
  endfunction

  // stored value of an attribute, zero when absent; slots compared in parallel
  function automatic logic [FIELD_W-1:0] lookup(row_t r, logic [FIELD_W-1:0] attr);
    logic [FIELD_W-1:0] v;
    v = '0;
    for (int j = 0; j < SLOTS_PER_USER; j++) begin
      if ((SCNT_W'(j) < r.count) && (r.slots[j].attr == attr)) begin
        v = r.slots[j].value;
      end
    end
    return v;
  endfunction

  function automatic logic pred(logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] v, logic t);
    return (t == TEST_EQUAL) ? (s == v) : ((s != '0) && (s != v));
  endfunction

  afme_ram #(.W(ROW_W), .D(MAX_USERS)) u_tab (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign row = row_t'(rdata);

  // query predicates on the row just read
  always_comb begin
    pa = pred(lookup(row, cmd_r.attr_a), cmd_r.value_a, cmd_r.test_a);
    pb = pred(lookup(row, cmd_r.attr_b), cmd_r.value_b, cmd_r.test_b);
    case (cmd_r.combine)
      COMB_AND: qmatch = pa && pb;
      COMB_OR:  qmatch = pa || pb;
      default:  qmatch = pa;
    endcase
  end

  // slot search and updated row for a set
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int j = 0; j < SLOTS_PER_USER; j++) begin
      if ((SCNT_W'(j) < row.count) && (row.slots[j].attr == cmd_r.attr_a)) begin
        hit_any = 1'b1;
        hit_idx = SIDX_W'(j);
      end
    end
    row_upd = row;
    if (hit_any) begin
      row_upd.slots[hit_idx].value = cmd_r.value_a;
    end else begin
      row_upd.slots[row.count[SIDX_W-1:0]].attr  = cmd_r.attr_a;
      row_upd.slots[row.count[SIDX_W-1:0]].value = cmd_r.value_a;
      row_upd.count = row.count + 1'b1;
    end
  end

  assign sh_dec = sh_r - 1'b1;

  // sequencer: next state, table port and results
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd_nxt       = cmd_r;
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = ridx_r;
    pos_nxt       = pos_r;
    sh_nxt        = sh_r;
    pend_nxt      = pend_r;
    pkey_nxt      = pkey_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = pos_r[UIDX_W-1:0];
    wdata         = rdata;
    raddr         = iss_r[UIDX_W-1:0];
    go_insert     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (head.vld) begin
          pop      = 1'b1;
          op_nxt   = head.op;
          cmd_nxt  = head.item;
          iss_nxt  = '0;
          pend_nxt = 1'b0;
          if (head.op == OP_NOP) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out(1'b0, '0, 1'b1, ST_OK);
          end else begin
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        // issue the next row read
        if (iss_r < n_r) begin
          rv_nxt   = 1'b1;
          ridx_nxt = iss_r[UIDX_W-1:0];
          iss_nxt  = iss_r + 1'b1;
        end
        if (rv_r) begin
          // evaluate the row read last cycle
          case (op_r)
            OP_DECLARE: begin
              if (row.key == cmd_r.user_id) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_out(1'b0, '0, 1'b1, ST_OK);
                state_nxt     = BK_IDLE;
                rv_nxt        = 1'b0;
              end else if (row.key > cmd_r.user_id) begin
                pos_nxt   = UCNT_W'(ridx_r);
                go_insert = 1'b1;
              end
            end
            OP_SET: begin
              if (row.key == cmd_r.user_id) begin
                out_valid_nxt = 1'b1;
                if (!hit_any && (row.count >= SCNT_W'(SLOTS_PER_USER))) begin
                  out_nxt = mk_out(1'b0, '0, 1'b1, ST_SLOTS_FULL);
                end else begin
                  out_nxt = mk_out(1'b0, '0, 1'b1, ST_OK);
                  we      = 1'b1;
                  waddr   = ridx_r;
                  wdata   = ROW_W'(row_upd);
                end
                state_nxt = BK_IDLE;
                rv_nxt    = 1'b0;
              end else if (row.key > cmd_r.user_id) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_out(1'b0, '0, 1'b1, ST_UNKNOWN);
                state_nxt     = BK_IDLE;
                rv_nxt        = 1'b0;
              end
            end
            default: begin
              // hold one match back so the final one can carry last
              if (qmatch) begin
                if (pend_r) begin
                  out_valid_nxt = 1'b1;
                  out_nxt       = mk_out(1'b1, pkey_r, 1'b0, ST_OK);
                end
                pend_nxt = 1'b1;
                pkey_nxt = row.key;
              end
            end
          endcase
        end else if (iss_r == n_r) begin
          // every record read without a stop
          case (op_r)
            OP_DECLARE: begin
              pos_nxt   = n_r;
              go_insert = 1'b1;
            end
            OP_SET: begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_out(1'b0, '0, 1'b1, ST_UNKNOWN);
              state_nxt     = BK_IDLE;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt = pend_r ? mk_out(1'b1, pkey_r, 1'b1, ST_OK)
                               : mk_out(1'b0, '0, 1'b1, ST_OK);
              state_nxt = BK_IDLE;
            end
          endcase
        end
        if (go_insert) begin
          rv_nxt = 1'b0;
          if (n_r == UCNT_W'(MAX_USERS)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out(1'b0, '0, 1'b1, ST_USERS_FULL);
            state_nxt     = BK_IDLE;
          end else begin
            sh_nxt    = n_r;
            state_nxt = BK_SHIFT_RD;
          end
        end
      end
      BK_SHIFT_RD: begin
        // move records above the insert point up by one
        raddr = sh_dec[UIDX_W-1:0];
        if (sh_r == pos_r) begin
          state_nxt = BK_INSERT;
        end else begin
          state_nxt = BK_SHIFT_WR;
        end
      end
      BK_SHIFT_WR: begin
        we        = 1'b1;
        waddr     = sh_r[UIDX_W-1:0];
        wdata     = rdata;
        sh_nxt    = sh_dec;
        state_nxt = BK_SHIFT_RD;
      end
      BK_INSERT: begin
        we            = 1'b1;
        waddr         = pos_r[UIDX_W-1:0];
        wdata         = {cmd_r.user_id, {(ROW_W - FIELD_W){1'b0}}};
        n_nxt         = n_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = mk_out(1'b0, '0, 1'b1, ST_OK);
        state_nxt     = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      n_r         <= '0;
      rv_r        <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      rv_r        <= rv_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    cmd_r  <= cmd_nxt;
    iss_r  <= iss_nxt;
    ridx_r <= ridx_nxt;
    pos_r  <= pos_nxt;
    sh_r   <= sh_nxt;
    pkey_r <= pkey_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/attribute_filter_match_engine_top.sv =====
// top level of the attribute filter match engine
// depends on afme_pkg, afme_front, afme_back (and afme_ram below it)
//
//   channel   ports                      handshake
//   input     start, busy, in_item       taken when start high, busy low
//   result    out_valid, out_item        one-cycle strobe, no back-pressure
//
// a query reads every stored record once in id order, one record per cycle
// from the record ram; a set stops at its own record or at the first one above it;
// a declare of a new user moves every record above its place up by one to
// open its place in the sorted table
// reset is synchronous, active low, and empties the table; busy rises when
// the two-entry command queue is full
module attribute_filter_match_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  afme_pkg::in_item_t  in_item,
  output logic                out_valid,
  output afme_pkg::out_item_t out_item
);
  import afme_pkg::*;

  q_head_t head;
  logic    pop;

  afme_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .pop     (pop),
    .head    (head)
  );

  afme_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/afme_checker.sv =====
// port-level checks on results of the match engine, bound to the top level
// depends on afme_pkg and attribute_filter_match_engine_top_defines.svh
`include "attribute_filter_match_engine_top_defines.svh"

module afme_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input afme_pkg::out_item_t out_item
);
  import afme_pkg::*;

  // a result with no user always closes its item
  `AFME_ASSERT_NOW(a_nomatch_last, out_valid && !out_item.has_match, out_item.last)
  // an empty result carries user zero
  `AFME_ASSERT_NOW(a_nomatch_zero, out_valid && !out_item.has_match, out_item.match_user == '0)
  // a match is always reported with ok status
  `AFME_ASSERT_NOW(a_match_ok, out_valid && out_item.has_match, out_item.status == ST_OK)

endmodule

bind attribute_filter_match_engine_top afme_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_item  (out_item)
);
